// File: hdl/pstd_pkg.sv
// ----------------------------------------------------------------------------
// pstd_pkg
// Types and constants shared by the string token decoder.
// ----------------------------------------------------------------------------
package pstd_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_LIT  = 2'd1,
        MODE_HEX  = 2'd2
    } parse_mode_t;

    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_NOT_STR = 3'd1;
    localparam logic [2:0] STATUS_BAD_HEX = 3'd2;
    localparam logic [2:0] STATUS_LIMIT   = 3'd3;
    localparam logic [2:0] STATUS_UNTERM  = 3'd4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;

    localparam logic [8:0] COUNT_MAX = 9'd511;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic [2:0] status;
    } out_item_t;

    function automatic out_item_t mk_res(logic [7:0] b, logic v, logic l, logic [2:0] s);
        out_item_t r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.last       = l;
        r.status     = s;
        return r;
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR) || (c == CH_NUL);
    endfunction

    function automatic logic is_octal(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    // bit 4 flags a valid hex digit
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [7:0] esc_map(logic [7:0] c);
        logic [7:0] b;
        case (c)
            8'h6e:   b = CH_LF;
            8'h72:   b = CH_CR;
            8'h74:   b = CH_TAB;
            8'h62:   b = CH_BS;
            8'h66:   b = CH_FF;
            default: b = c;
        endcase
        return b;
    endfunction

endpackage

// File: hdl/pdf_string_token_decoder.sv
// ----------------------------------------------------------------------------
// pdf_string_token_decoder
// Decodes literal and hex string tokens from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one raw byte per item (or an end-of-input marker).
//   m_* channel delivers decoded bytes and one closing item per token with
//   last set and a status code.
//   Each input item is decoded in the cycle it is accepted; its zero, one or
//   two results are registered into a four-entry output queue that drives
//   m_*. Input rate is one item per cycle while the receiver keeps up;
//   sustained rate is bounded by the one result per cycle the output queue
//   drains.
//   s_ready is high while the queue has room for two results; a stalled
//   receiver holds the input once three results wait, with nothing lost.
//   Reset clears the parser to idle and empties the output queue.
// ----------------------------------------------------------------------------
module pdf_string_token_decoder import pstd_pkg::*; #(
    parameter int MAX_RAW = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam logic [8:0] RAW_LIMIT = 9'(MAX_RAW);

    parse_mode_t mode_reg, mode_next;
    logic [8:0]  depth_reg, depth_next;
    logic        esc_reg, esc_next;
    logic [1:0]  od_reg, od_next;
    logic [7:0]  ov_reg, ov_next;
    logic [8:0]  raw_reg, raw_next;
    logic [3:0]  hn_reg, hn_next;
    logic        half_reg, half_next;

    out_item_t   res [2];
    logic [1:0]  n;

    out_item_t   fifo_reg [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg, count_next;

    logic        s_fire, m_fire;
    logic [7:0]  c;
    logic        eoi;
    logic        closed;
    logic        plain;
    logic [4:0]  hv;

    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign s_ready = (count_reg <= 3'd2);
    assign m_valid = (count_reg != 3'd0);
    assign m_data  = fifo_reg[rd_ptr_reg];
    assign c       = s_data.in_byte;
    assign eoi     = s_data.end_of_input;
    assign hv      = hex_val(c);

    always_comb begin
        mode_next  = mode_reg;
        depth_next = depth_reg;
        esc_next   = esc_reg;
        od_next    = od_reg;
        ov_next    = ov_reg;
        raw_next   = raw_reg;
        hn_next    = hn_reg;
        half_next  = half_reg;
        res[0]     = mk_res(8'd0, 1'b0, 1'b0, STATUS_OK);
        res[1]     = mk_res(8'd0, 1'b0, 1'b0, STATUS_OK);
        n          = 2'd0;
        closed     = 1'b0;
        plain      = 1'b0;

        case (mode_reg)
            MODE_LIT, MODE_HEX: begin
                if (eoi) begin
                    if (od_reg != 2'd0) begin
                        res[0] = mk_res(ov_reg, 1'b1, 1'b0, STATUS_OK);
                        n = 2'd1;
                    end
                    res[n[0]] = mk_res(8'd0, 1'b0, 1'b1, STATUS_UNTERM);
                    n = n + 2'd1;
                    closed = 1'b1;
                end else if (mode_reg == MODE_LIT) begin
                    if (raw_reg != COUNT_MAX) begin
                        raw_next = raw_reg + 9'd1;
                    end
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        if (is_octal(c)) begin
                            od_next = 2'd1;
                            ov_next = {5'd0, c[2:0]};
                        end else begin
                            res[0] = mk_res(esc_map(c), 1'b1, 1'b0, STATUS_OK);
                            n = 2'd1;
                        end
                    end else if (od_reg != 2'd0) begin
                        if (is_octal(c) && od_reg != 2'd3 && ov_reg < 8'd32) begin
                            ov_next = {ov_reg[4:0], c[2:0]};
                            od_next = od_reg + 2'd1;
                            if (od_reg == 2'd2) begin
                                res[0] = mk_res({ov_reg[4:0], c[2:0]}, 1'b1, 1'b0, STATUS_OK);
                                n = 2'd1;
                                od_next = 2'd0;
                                ov_next = 8'd0;
                            end
                        end else begin
                            res[0] = mk_res(ov_reg, 1'b1, 1'b0, STATUS_OK);
                            n = 2'd1;
                            od_next = 2'd0;
                            ov_next = 8'd0;
                            plain = 1'b1;
                        end
                    end else begin
                        plain = 1'b1;
                    end

                    if (plain) begin
                        if (c == CH_LPAREN) begin
                            if (depth_reg != COUNT_MAX) begin
                                depth_next = depth_reg + 9'd1;
                            end
                            res[n[0]] = mk_res(c, 1'b1, 1'b0, STATUS_OK);
                            n = n + 2'd1;
                        end else if (c == CH_RPAREN) begin
                            if (depth_reg != 9'd0) begin
                                depth_next = depth_reg - 9'd1;
                            end
                            if (depth_reg <= 9'd1) begin
                                closed = 1'b1;
                            end else begin
                                res[n[0]] = mk_res(c, 1'b1, 1'b0, STATUS_OK);
                                n = n + 2'd1;
                            end
                        end else if (c == CH_BSLASH) begin
                            esc_next = 1'b1;
                        end else begin
                            res[n[0]] = mk_res(c, 1'b1, 1'b0, STATUS_OK);
                            n = n + 2'd1;
                        end
                    end

                    if (closed) begin
                        res[n[0]] = mk_res(8'd0, 1'b0, 1'b1, STATUS_OK);
                        n = n + 2'd1;
                    end else if (raw_next >= RAW_LIMIT) begin
                        if (od_next != 2'd0) begin
                            res[n[0]] = mk_res(ov_next, 1'b1, 1'b0, STATUS_OK);
                            n = n + 2'd1;
                        end
                        if (n != 2'd0) begin
                            res[n[0] ^ 1'b1].last   = 1'b1;
                            res[n[0] ^ 1'b1].status = STATUS_LIMIT;
                        end else begin
                            res[0] = mk_res(8'd0, 1'b0, 1'b1, STATUS_LIMIT);
                            n = 2'd1;
                        end
                        closed = 1'b1;
                    end
                end else begin
                    if (c == CH_GT) begin
                        res[0] = mk_res(8'd0, 1'b0, 1'b1,
                            (raw_reg == 9'd0 || half_reg) ? STATUS_BAD_HEX : STATUS_OK);
                        n = 2'd1;
                        closed = 1'b1;
                    end else if (hv[4]) begin
                        if (raw_reg != COUNT_MAX) begin
                            raw_next = raw_reg + 9'd1;
                        end
                        if (!half_reg) begin
                            hn_next   = hv[3:0];
                            half_next = 1'b1;
                        end else begin
                            res[0] = mk_res({hn_reg, hv[3:0]}, 1'b1, 1'b0, STATUS_OK);
                            n = 2'd1;
                            half_next = 1'b0;
                            hn_next   = 4'd0;
                        end
                        if (raw_next >= RAW_LIMIT) begin
                            if (n != 2'd0) begin
                                res[0].last   = 1'b1;
                                res[0].status = STATUS_LIMIT;
                            end else begin
                                res[0] = mk_res(8'd0, 1'b0, 1'b1, STATUS_LIMIT);
                                n = 2'd1;
                            end
                            closed = 1'b1;
                        end
                    end
                end
            end
            default: begin
                mode_next = MODE_IDLE;
                if (eoi) begin
                    res[0] = mk_res(8'd0, 1'b0, 1'b1, STATUS_NOT_STR);
                    n = 2'd1;
                end else if (is_ws(c)) begin
                    n = 2'd0;
                end else if (c == CH_LPAREN) begin
                    closed = 1'b1;
                end else if (c == CH_LT) begin
                    closed = 1'b1;
                end else begin
                    res[0] = mk_res(8'd0, 1'b0, 1'b1, STATUS_NOT_STR);
                    n = 2'd1;
                end
            end
        endcase

        if (closed) begin
            mode_next  = MODE_IDLE;
            depth_next = 9'd0;
            esc_next   = 1'b0;
            od_next    = 2'd0;
            ov_next    = 8'd0;
            raw_next   = 9'd0;
            hn_next    = 4'd0;
            half_next  = 1'b0;
            if (mode_reg != MODE_LIT && mode_reg != MODE_HEX && !eoi) begin
                if (c == CH_LPAREN) begin
                    mode_next  = MODE_LIT;
                    depth_next = 9'd1;
                end else begin
                    mode_next  = MODE_HEX;
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (s_fire) begin
            count_next = count_next + {1'b0, n};
        end
        if (m_fire) begin
            count_next = count_next - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            depth_reg  <= 9'd0;
            esc_reg    <= 1'b0;
            od_reg     <= 2'd0;
            ov_reg     <= 8'd0;
            raw_reg    <= 9'd0;
            hn_reg     <= 4'd0;
            half_reg   <= 1'b0;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (s_fire) begin
                mode_reg   <= mode_next;
                depth_reg  <= depth_next;
                esc_reg    <= esc_next;
                od_reg     <= od_next;
                ov_reg     <= ov_next;
                raw_reg    <= raw_next;
                hn_reg     <= hn_next;
                half_reg   <= half_next;
                wr_ptr_reg <= wr_ptr_reg + n;
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (n != 2'd0) begin
                fifo_reg[wr_ptr_reg] <= res[0];
            end
            if (n == 2'd2) begin
                fifo_reg[wr_ptr_reg + 2'd1] <= res[1];
            end
        end
    end

endmodule
